FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property that is switched off while reset is high.
`define IPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property that is also checked during reset.
`define IPC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPC_ASSERT(lbl, clk, rst, prop, msg)
`define IPC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/ipc_pkg.sv
package ipc_pkg;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  // Pending flags are OR-reduced in groups of this many bits per stage.
  localparam int RED_GROUP = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_HEIGHT = 1'b0,
    REG_GRID_WIDTH  = 1'b1
  } cfg_reg_t;

  // Frame status handed from the scan stage to the reduction stages.
  typedef struct packed {
    logic last;
    logic found;
  } frame_stat_t;

  // Bits needed to hold a clamped dimension and compare it to a raw register value.
  function automatic int dim_bits(input int max_dim);
    int b;
    b = $clog2(max_dim + 1);
    return (b > CFG_DATA_W) ? b : CFG_DATA_W;
  endfunction

endpackage

FILE: rtl/core/ipc_pixel_if.sv
interface ipc_pixel_if;
  logic valid;
  logic ready;
  logic pixel_set;

  modport source (output valid, output pixel_set, input ready);
  modport sink (input valid, input pixel_set, output ready);
endinterface

FILE: rtl/core/ipc_result_if.sv
interface ipc_result_if;
  logic valid;
  logic ready;
  logic all_connected;

  modport source (output valid, output all_connected, input ready);
  modport sink (input valid, input all_connected, output ready);
endinterface

FILE: rtl/core/ipc_cfg_if.sv
interface ipc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ipc_pkg::CFG_IDX_W-1:0]  index;
  logic [ipc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ipc_ram.sv
module ipc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the output holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/ipc_scan.sv
`include "assert_macros.svh"

module ipc_scan #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         go,
  input  logic                                         pixel_set,
  input  logic [ipc_pkg::dim_bits(MAX_WIDTH)-1:0]      width_eff,
  input  logic [ipc_pkg::dim_bits(MAX_HEIGHT)-1:0]     height_eff,
  output ipc_pkg::frame_stat_t                         stat,
  output logic [MAX_WIDTH-1:0]                         snap_vec
);

  localparam int WDW = ipc_pkg::dim_bits(MAX_WIDTH);
  localparam int HDW = ipc_pkg::dim_bits(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);

  logic [CW-1:0]        col;
  logic [CW-1:0]        col_next;
  logic [RW-1:0]        row;
  logic [RW-1:0]        row_next;
  logic                 left_pixel;
  logic                 left_pixel_next;
  logic                 found_isolated;
  logic                 found_isolated_next;
  logic [MAX_WIDTH-1:0] pending;
  logic [MAX_WIDTH-1:0] pending_next;
  logic                 byp_valid;
  logic                 byp_data;

  logic [0:0]           ram_rdata;
  logic [0:0]           ram_wdata;
  logic                 first_row;
  logic                 up;
  logic                 has_left;
  logic                 found_step;
  logic [MAX_WIDTH-1:0] pend_step;
  logic                 row_end;
  logic                 frame_end;

  // Line store for the previous row, read one pixel ahead of use.
  assign ram_wdata = pixel_set;

  ipc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (go),
    .waddr (col),
    .wdata (ram_wdata),
    .re    (go),
    .raddr (col_next),
    .rdata (ram_rdata)
  );

  // Neighbor terms for the current pixel. A single-column image reads the
  // entry just written, so that case comes from the bypass register.
  always_comb begin
    first_row  = (row == '0);
    up         = !first_row && (byp_valid ? byp_data : ram_rdata[0]);
    has_left   = (col != '0) && left_pixel;
    found_step = found_isolated || (!first_row && pending[col] && !pixel_set);
    row_end    = ((WDW'(col) + WDW'(1)) >= width_eff);
    frame_end  = row_end && ((HDW'(row) + HDW'(1)) >= height_eff);
  end

  // Pending flags after this pixel: the left neighbor is connected by a set
  // pixel, and the current column takes a fresh flag.
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      if (CW'(i) == col) begin
        pend_step[i] = pixel_set && !up && !has_left;
      end else if (has_left && pixel_set && (CW'(i) == (col - CW'(1)))) begin
        pend_step[i] = 1'b0;
      end else begin
        pend_step[i] = pending[i];
      end
    end
  end

  // Columns beyond the image width do not take part in the final check.
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      snap_vec[i] = pend_step[i] && (WDW'(i) < width_eff);
    end
  end

  assign stat.last  = go && frame_end;
  assign stat.found = found_step;

  // Position and frame state update.
  always_comb begin
    if (frame_end) begin
      col_next            = '0;
      row_next            = '0;
      left_pixel_next     = 1'b0;
      found_isolated_next = 1'b0;
      pending_next        = '0;
    end else if (row_end) begin
      col_next            = '0;
      row_next            = row + RW'(1);
      left_pixel_next     = 1'b0;
      found_isolated_next = found_step;
      pending_next        = pend_step;
    end else begin
      col_next            = col + CW'(1);
      row_next            = row;
      left_pixel_next     = pixel_set;
      found_isolated_next = found_step;
      pending_next        = pend_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col            <= '0;
      row            <= '0;
      left_pixel     <= 1'b0;
      found_isolated <= 1'b0;
      pending        <= '0;
      byp_valid      <= 1'b0;
    end else if (go) begin
      col            <= col_next;
      row            <= row_next;
      left_pixel     <= left_pixel_next;
      found_isolated <= found_isolated_next;
      pending        <= pending_next;
      byp_valid      <= (col_next == col);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      byp_data <= pixel_set;
    end
  end

  `IPC_ASSERT(a_frame_clear, clk, rst, go && frame_end |=> col == '0 && row == '0 && !found_isolated && pending == '0, "frame state not cleared after last pixel")
  `IPC_ASSERT(a_row_wrap, clk, rst, go && row_end && !frame_end |=> col == '0 && row == $past(row) + RW'(1), "row advance wrong at end of row")

endmodule

FILE: rtl/core/ipc_reduce.sv
`include "assert_macros.svh"

module ipc_reduce #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ipc_pkg::frame_stat_t stat,
  input  logic [MAX_WIDTH-1:0] snap_vec,
  output logic                 snap_ready,
  ipc_result_if.source         result
);

  localparam int GROUPS = (MAX_WIDTH + ipc_pkg::RED_GROUP - 1) / ipc_pkg::RED_GROUP;
  localparam int PADW   = GROUPS * ipc_pkg::RED_GROUP;

  logic              a_valid;
  logic              a_found;
  logic [PADW-1:0]   a_vec;
  logic              b_valid;
  logic              b_found;
  logic [GROUPS-1:0] b_grp;
  logic [GROUPS-1:0] b_grp_next;
  logic              c_valid;
  logic              c_conn;
  logic              a_free;
  logic              b_free;
  logic              c_free;

  // Each stage moves when the one after it has room.
  assign c_free     = !c_valid || result.ready;
  assign b_free     = !b_valid || c_free;
  assign a_free     = !a_valid || b_free;
  assign snap_ready = a_free;

  // First level of the OR tree: one flag per group of pending bits.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      b_grp_next[g] = |a_vec[g*ipc_pkg::RED_GROUP +: ipc_pkg::RED_GROUP];
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= stat.last;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (c_free) begin
        c_valid <= b_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (a_free) begin
      a_found <= stat.found;
      a_vec   <= PADW'(snap_vec);
    end
    if (b_free) begin
      b_found <= a_found;
      b_grp   <= b_grp_next;
    end
    if (c_free) begin
      c_conn <= !(b_found || (b_grp != '0));
    end
  end

  assign result.valid         = c_valid;
  assign result.all_connected = c_conn;

  `IPC_ASSERT(a_snap_moves, clk, rst, a_valid && b_free |=> b_valid, "snapshot lost between stages")
  `IPC_ASSERT(a_result_value, clk, rst, b_valid && c_free |=> c_valid && c_conn == !($past(b_found) || ($past(b_grp) != '0)), "result does not match reduced flags")
  `IPC_ASSERT_NR(a_reset_idle, clk, rst |=> !c_valid && !b_valid && !a_valid, "result pipeline not empty after reset")

endmodule

FILE: rtl/core/isolated_pixel_check_core.sv
// Checks a binary image, streamed one pixel per request in row-major order, for
// set pixels with no set up, down, left or right neighbor; grid_height (index 0)
// and grid_width (index 1) set the frame size, where 0 acts as 1 and values above
// MAX_HEIGHT or MAX_WIDTH act as that maximum. One request on all_connected
// follows the last pixel of each frame: 1 when no set pixel is isolated, which
// includes an all-clear image, and the block is then ready for the next frame.
// A pixel is taken every clock while the result path has room; the pace is set by
// the column update of the pending flags and the previous-row line RAM, whose
// read is issued one column ahead. The result leaves through a two-stage OR tree
// over the pending flags, held in reduction registers a, b and c. No clearing
// pass is needed after reset.
module isolated_pixel_check_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic         clk,
  input  logic         rst,
  ipc_pixel_if.sink    pixel,
  ipc_result_if.source result,
  ipc_cfg_if.sink      cfg
);

  localparam int WDW = ipc_pkg::dim_bits(MAX_WIDTH);
  localparam int HDW = ipc_pkg::dim_bits(MAX_HEIGHT);

  logic [WDW-1:0]       width_eff;
  logic [HDW-1:0]       height_eff;
  logic                 in_valid;
  logic                 in_pix;
  logic                 scan_go;
  logic                 snap_ready;
  ipc_pkg::frame_stat_t stat;
  logic [MAX_WIDTH-1:0] snap_vec;

  function automatic logic [WDW-1:0] clamp_w(input logic [ipc_pkg::CFG_DATA_W-1:0] v);
    logic [WDW-1:0] ve;
    ve = WDW'(v);
    if (v == '0) begin
      return WDW'(1);
    end else if (ve > WDW'(MAX_WIDTH)) begin
      return WDW'(MAX_WIDTH);
    end
    return ve;
  endfunction

  function automatic logic [HDW-1:0] clamp_h(input logic [ipc_pkg::CFG_DATA_W-1:0] v);
    logic [HDW-1:0] ve;
    ve = HDW'(v);
    if (v == '0) begin
      return HDW'(1);
    end else if (ve > HDW'(MAX_HEIGHT)) begin
      return HDW'(MAX_HEIGHT);
    end
    return ve;
  endfunction

  // Configuration registers hold the clamped frame size.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_eff <= HDW'(1);
      width_eff  <= WDW'(1);
    end else if (cfg.valid) begin
      case (ipc_pkg::cfg_reg_t'(cfg.index))
        ipc_pkg::REG_GRID_HEIGHT: height_eff <= clamp_h(cfg.data);
        ipc_pkg::REG_GRID_WIDTH:  width_eff  <= clamp_w(cfg.data);
        default: ;
      endcase
    end
  end

  // Input register; it drains into the scan stage whenever the result path has room.
  assign scan_go     = in_valid && snap_ready;
  assign pixel.ready = !in_valid || scan_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixel.ready) begin
      in_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready) begin
      in_pix <= pixel.pixel_set;
    end
  end

  // Per-pixel neighbor tracking.
  ipc_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .go         (scan_go),
    .pixel_set  (in_pix),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .stat       (stat),
    .snap_vec   (snap_vec)
  );

  // End-of-frame reduction and result register.
  ipc_reduce #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_reduce (
    .clk        (clk),
    .rst        (rst),
    .stat       (stat),
    .snap_vec   (snap_vec),
    .snap_ready (snap_ready),
    .result     (result)
  );

endmodule
